[hdl/atl_pkg.sv]
`default_nettype none
package atl_pkg;

  // field widths
  localparam int IN_W    = 16;
  localparam int ANG_W   = 17;
  localparam int OUT_W   = 18;
  localparam int THR_W   = 15;

  // angle format
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int Q16_SHIFT       = 16;
  localparam int ROUND_SHIFT     = Q16_SHIFT - ANGLE_FRAC_BITS;

  // cordic datapath
  localparam int CW           = 28;
  localparam int ZW           = 26;
  localparam int PRE_SHIFT    = 8;
  localparam int CORDIC_STEPS = 18;
  localparam logic signed [ZW-1:0] DEG90_Q16  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1 << (ROUND_SHIFT - 1));
  localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945), ZW'(234379),
    ZW'(117304), ZW'(58666), ZW'(29335), ZW'(14668), ZW'(7334), ZW'(3667),
    ZW'(1833), ZW'(917), ZW'(458), ZW'(229), ZW'(115), ZW'(57), ZW'(29)
  };

  // root and divide units
  localparam int SQ_IN_W   = 48;
  localparam int SQ_ROOT_W = 24;
  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = 19;

  // smoother: divide by five via reciprocal
  localparam logic [15:0] FIFTH_MUL   = 16'd52429;
  localparam int          FIFTH_SHIFT = 18;

  // board geometry
  localparam int BOARD_PIXELS  = 160;
  localparam int BUBBLE_PIXELS = 24;
  localparam int SPAN          = BOARD_PIXELS - BUBBLE_PIXELS - 8;
  localparam int CENTER        = BOARD_PIXELS / 2 - BUBBLE_PIXELS / 2;
  localparam logic [17:0] CLAMP_ANGLE = 18'(15 << ANGLE_FRAC_BITS);

  // threshold registers
  localparam logic [0:0] REG_LEVEL  = 1'b0;
  localparam logic [0:0] REG_SLIGHT = 1'b1;
  localparam logic [THR_W-1:0] LEVEL_RESET  = THR_W'((3 << ANGLE_FRAC_BITS) / 2);
  localparam logic [THR_W-1:0] SLIGHT_RESET = THR_W'(5 << ANGLE_FRAC_BITS);

  // tilt classes
  localparam logic [1:0] CLASS_LEVEL  = 2'd0;
  localparam logic [1:0] CLASS_SLIGHT = 2'd1;
  localparam logic [1:0] CLASS_STRONG = 2'd2;

  typedef struct packed {
    logic                 vld;
    logic                 tag;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage
`default_nettype wire

[hdl/atl_cordic_cell.sv]
`default_nettype none
module atl_cordic_cell
  import atl_pkg::*;
#(
  parameter int                   SHIFT = 0,
  parameter logic signed [ZW-1:0] ATAN  = '0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cordic_t cell_in,
  output cordic_t      cell_out
);

  logic signed [CW-1:0] x_in, y_in;
  logic signed [ZW-1:0] z_in;
  cordic_t stage_r, stage_nxt;

  assign x_in = cell_in.x;
  assign y_in = cell_in.y;
  assign z_in = cell_in.z;

  // one vectoring micro-rotation
  always_comb begin
    stage_nxt = cell_in;
    if (y_in > 0) begin
      stage_nxt.x = x_in + (y_in >>> SHIFT);
      stage_nxt.y = y_in - (x_in >>> SHIFT);
      stage_nxt.z = z_in + ATAN;
    end else begin
      stage_nxt.x = x_in - (y_in >>> SHIFT);
      stage_nxt.y = y_in + (x_in >>> SHIFT);
      stage_nxt.z = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign cell_out = stage_r;

endmodule
`default_nettype wire

[hdl/atl_isqrt.sv]
`default_nettype none
module atl_isqrt
  import atl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [SQ_IN_W-1:0] radicand,
  output logic                    done,
  output logic [SQ_ROOT_W-1:0]    root
);

  localparam int RW  = SQ_ROOT_W + 3;
  localparam int CNW = $clog2(SQ_ROOT_W);

  logic                 busy_r, done_r;
  logic [CNW-1:0]       cnt_r;
  logic [SQ_IN_W-1:0]   sh_r;
  logic [RW-1:0]        rem_r, rem_t, trial;
  logic [SQ_ROOT_W-1:0] root_r;
  logic                 ge;

  // one root bit per cycle
  assign rem_t = {rem_r[RW-3:0], sh_r[SQ_IN_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        sh_r   <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        sh_r   <= sh_r << 2;
        rem_r  <= ge ? rem_t - trial : rem_t;
        root_r <= {root_r[SQ_ROOT_W-2:0], ge};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNW'(SQ_ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

[hdl/atl_div.sv]
`default_nettype none
module atl_div
  import atl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quo
);

  localparam int CNW = $clog2(DIV_NUM_W);

  logic                 busy_r, done_r;
  logic [CNW-1:0]       cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r, rem_r;
  logic [DIV_DEN_W:0]   rem_t, diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign rem_t = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge    = rem_t >= {1'b0, den_r};
  assign diff  = rem_t - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_DEN_W-1:0] : rem_t[DIV_DEN_W-1:0];
        num_r <= {num_r[DIV_NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule
`default_nettype wire

[hdl/accel_tilt_level_indicator_core.sv]
// Tilt inclinometer core: one three-axis accelerometer sample in, one reading out.
// Input channel (in_valid / in_stall): op (0 measure, 1 calibrate), sample_ok and
// the three signed axes. Result channel (out_valid / out_stall): reading_ok,
// offset-corrected roll and pitch in 1/256 degree, tilt class and bubble pixel.
// Configuration: cfg_we writes cfg_wdata to the level (index 0) or slight
// (index 1) threshold; write only while no request is in flight.
// Requests are handled one at a time. The processing time is set by the
// 18-cell CORDIC chain (used once per angle), the bit-serial square root
// (used twice) and the bit-serial bubble dividers. An invalid sample skips
// the datapath and goes straight to the output register stage.
// in_stall is high from acceptance until the result is moved into the output
// register, so a new request may be taken while the previous result still
// waits. When the receiver stalls, the finished result holds in the output
// register and the core waits before handing over the next one.
// Reset clears the smoother, the zero offsets and the priming flag, and loads
// the thresholds with 1.5 and 5 degrees.
`default_nettype none
module accel_tilt_level_indicator_core
  import atl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_op,
  input  wire logic                    in_sample_ok,
  input  wire logic signed [IN_W-1:0]  in_accel_x,
  input  wire logic signed [IN_W-1:0]  in_accel_y,
  input  wire logic signed [IN_W-1:0]  in_accel_z,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_reading_ok,
  output logic signed [OUT_W-1:0]      out_roll_out,
  output logic signed [OUT_W-1:0]      out_pitch_out,
  output logic [1:0]                   out_tilt_class,
  output logic [7:0]                   out_bubble_x,
  output logic [7:0]                   out_bubble_y,
  input  wire logic                    cfg_we,
  input  wire logic [0:0]              cfg_index,
  input  wire logic [THR_W-1:0]        cfg_wdata
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQ1S   = 4'd1;
  localparam logic [3:0] ST_SQ1W   = 4'd2;
  localparam logic [3:0] ST_PITCH  = 4'd3;
  localparam logic [3:0] ST_WAITC  = 4'd4;
  localparam logic [3:0] ST_SMOOTH = 4'd5;
  localparam logic [3:0] ST_OFFS   = 4'd6;
  localparam logic [3:0] ST_SUMSQ  = 4'd7;
  localparam logic [3:0] ST_SQ2S   = 4'd8;
  localparam logic [3:0] ST_SQ2W   = 4'd9;
  localparam logic [3:0] ST_DIV    = 4'd10;
  localparam logic [3:0] ST_DIVW   = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  localparam int EXT = CW - IN_W - PRE_SHIFT;

  function automatic cordic_t cordic_entry(input logic tag,
                                           input logic signed [CW-1:0] y,
                                           input logic signed [CW-1:0] x);
    cordic_t e;
    e.vld = 1'b1;
    e.tag = tag;
    e.x   = x;
    e.y   = y;
    e.z   = '0;
    if (x < 0) begin
      if (y >= 0) begin
        e.x = y;
        e.y = -x;
        e.z = DEG90_Q16;
      end else begin
        e.x = -y;
        e.y = x;
        e.z = -DEG90_Q16;
      end
    end
    return e;
  endfunction

  // rounded fifth of a signed difference
  function automatic logic signed [ANG_W-1:0] fifth(input logic signed [ANG_W:0] d);
    logic [ANG_W:0]    n;
    logic [ANG_W+16:0] p;
    logic [ANG_W-1:0]  q;
    n = (d < 0 ? -d : d) + (ANG_W+1)'(2);
    p = n * FIFTH_MUL;
    q = p[FIFTH_SHIFT +: ANG_W];
    return (d < 0) ? -$signed(q) : $signed(q);
  endfunction

  logic [3:0]                state_r, state_nxt;
  logic                      accept;
  logic                      op_r, ok_r;
  logic signed [IN_W-1:0]    ax_r;
  logic                      roll_zv_r, pitch_zv_r;
  logic signed [31:0]        sq_y, sq_z;
  logic [31:0]               yz_r;
  logic signed [ANG_W-1:0]   raw_roll_r, raw_pitch_r;
  logic signed [ANG_W-1:0]   sm_roll_r, sm_pitch_r, zr_roll_r, zr_pitch_r;
  logic                      primed_r, prime;
  logic signed [OUT_W-1:0]   roll_r, pitch_r;
  logic [OUT_W-1:0]          abs_roll, abs_pitch, mag;
  logic [1:0]                cls;
  logic signed [35:0]        sq_roll, sq_pitch;
  logic [35:0]               sumsq_r;
  logic [THR_W-1:0]          level_r, slight_r;
  logic signed [CW-1:0]      roll_y, roll_x, pitch_y, pitch_x, ax_ext;
  cordic_t                   chain [CORDIC_STEPS+1];
  cordic_t                   chain_out;
  logic signed [ZW-1:0]      zc, zr;
  logic signed [ANG_W-1:0]   ang_conv;
  logic                      sq_start, sq_done;
  logic [SQ_IN_W-1:0]        sq_radicand;
  logic [SQ_ROOT_W-1:0]      sq_root;
  logic [17:0]               root18, root_cl;
  logic [DIV_DEN_W-1:0]      den;
  logic                      div_start, divx_done, divy_done;
  logic [DIV_NUM_W-1:0]      numx, numy, quox, quoy;
  logic signed [ANG_W:0]     d_roll, d_pitch;
  logic                      out_valid_r;
  logic                      load_out;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = state_r != ST_IDLE;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= LEVEL_RESET;
      slight_r <= SLIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL:  level_r  <= cfg_wdata;
        REG_SLIGHT: slight_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // cordic entry vectors
  assign roll_y  = {{EXT{in_accel_y[IN_W-1]}}, in_accel_y, {PRE_SHIFT{1'b0}}};
  assign roll_x  = {{EXT{in_accel_z[IN_W-1]}}, in_accel_z, {PRE_SHIFT{1'b0}}};
  assign ax_ext  = {{EXT{ax_r[IN_W-1]}}, ax_r, {PRE_SHIFT{1'b0}}};
  assign pitch_y = -ax_ext;
  assign pitch_x = {{(CW-SQ_ROOT_W){1'b0}}, sq_root};

  always_comb begin
    chain[0] = '0;
    if (accept && in_sample_ok) begin
      chain[0] = cordic_entry(1'b0, roll_y, roll_x);
    end else if (state_r == ST_PITCH) begin
      chain[0] = cordic_entry(1'b1, pitch_y, pitch_x);
    end
  end

  // row of cordic cells
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    atl_cordic_cell #(
      .SHIFT (g),
      .ATAN  (ATAN_Q16[g])
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  assign chain_out = chain[CORDIC_STEPS];

  // clamp and round the chain angle
  always_comb begin
    zc = chain_out.z;
    if (zc > DEG180_Q16) begin
      zc = DEG180_Q16;
    end else if (zc < -DEG180_Q16) begin
      zc = -DEG180_Q16;
    end
    zr = zc + ROUND_HALF;
  end
  assign ang_conv = zr[ROUND_SHIFT +: ANG_W];

  // shared root unit
  assign sq_start    = (state_r == ST_SQ1S) || (state_r == ST_SQ2S);
  assign sq_radicand = (state_r == ST_SQ1S) ? {yz_r, 16'b0} : {12'b0, sumsq_r};

  atl_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  // bubble dividers
  assign root18    = sq_root[17:0];
  assign root_cl   = (root18 < CLAMP_ANGLE) ? CLAMP_ANGLE : root18;
  assign den       = {root_cl, 1'b0};
  assign abs_roll  = (roll_r < 0) ? -roll_r : roll_r;
  assign abs_pitch = (pitch_r < 0) ? -pitch_r : pitch_r;
  assign numx      = DIV_NUM_W'(abs_roll * SPAN);
  assign numy      = DIV_NUM_W'(abs_pitch * SPAN);
  assign div_start = state_r == ST_DIV;

  atl_div u_divx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (numx),
    .den   (den),
    .done  (divx_done),
    .quo   (quox)
  );

  atl_div u_divy (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (numy),
    .den   (den),
    .done  (divy_done),
    .quo   (quoy)
  );

  // tilt class
  assign mag = (abs_roll > abs_pitch) ? abs_roll : abs_pitch;
  always_comb begin
    if (mag < {3'b0, level_r}) begin
      cls = CLASS_LEVEL;
    end else if (mag < {3'b0, slight_r}) begin
      cls = CLASS_SLIGHT;
    end else begin
      cls = CLASS_STRONG;
    end
  end

  // squares
  assign sq_y     = in_accel_y * in_accel_y;
  assign sq_z     = in_accel_z * in_accel_z;
  assign sq_roll  = roll_r * roll_r;
  assign sq_pitch = pitch_r * pitch_r;

  // smoother differences
  assign prime   = ~op_r & primed_r;
  assign d_roll  = {raw_roll_r[ANG_W-1], raw_roll_r} - {sm_roll_r[ANG_W-1], sm_roll_r};
  assign d_pitch = {raw_pitch_r[ANG_W-1], raw_pitch_r} - {sm_pitch_r[ANG_W-1], sm_pitch_r};

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = in_sample_ok ? ST_SQ1S : ST_DONE;
      ST_SQ1S:   state_nxt = ST_SQ1W;
      ST_SQ1W:   if (sq_done) state_nxt = ST_PITCH;
      ST_PITCH:  state_nxt = ST_WAITC;
      ST_WAITC:  if (chain_out.vld && chain_out.tag) state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = ST_OFFS;
      ST_OFFS:   state_nxt = ST_SUMSQ;
      ST_SUMSQ:  state_nxt = ST_SQ2S;
      ST_SQ2S:   state_nxt = ST_SQ2W;
      ST_SQ2W:   if (sq_done) state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_DIVW;
      ST_DIVW:   if (divx_done) state_nxt = ST_DONE;
      ST_DONE:   if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      sm_roll_r   <= '0;
      sm_pitch_r  <= '0;
      zr_roll_r   <= '0;
      zr_pitch_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SMOOTH) begin
        primed_r <= 1'b1;
        if (op_r) begin
          zr_roll_r  <= raw_roll_r;
          zr_pitch_r <= raw_pitch_r;
        end
        if (prime) begin
          sm_roll_r  <= sm_roll_r + fifth(d_roll);
          sm_pitch_r <= sm_pitch_r + fifth(d_pitch);
        end else begin
          sm_roll_r  <= raw_roll_r;
          sm_pitch_r <= raw_pitch_r;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload and working values
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      ok_r      <= in_sample_ok;
      ax_r      <= in_accel_x;
      roll_zv_r <= (in_accel_y == '0) && (in_accel_z == '0);
      yz_r      <= $unsigned(sq_y) + $unsigned(sq_z);
    end
    if (state_r == ST_PITCH) begin
      pitch_zv_r <= (ax_r == '0) && (sq_root == '0);
    end
    if (chain_out.vld && !chain_out.tag) begin
      raw_roll_r <= roll_zv_r ? '0 : ang_conv;
    end
    if (chain_out.vld && chain_out.tag) begin
      raw_pitch_r <= pitch_zv_r ? '0 : ang_conv;
    end
    if (state_r == ST_OFFS) begin
      roll_r  <= {sm_roll_r[ANG_W-1], sm_roll_r} - {zr_roll_r[ANG_W-1], zr_roll_r};
      pitch_r <= {sm_pitch_r[ANG_W-1], sm_pitch_r} - {zr_pitch_r[ANG_W-1], zr_pitch_r};
    end
    if (state_r == ST_SUMSQ) begin
      sumsq_r <= $unsigned(sq_roll) + $unsigned(sq_pitch);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_reading_ok <= ok_r;
      if (ok_r) begin
        out_roll_out   <= roll_r;
        out_pitch_out  <= pitch_r;
        out_tilt_class <= cls;
        out_bubble_x   <= 8'(CENTER) + ((roll_r < 0) ? -quox[7:0] : quox[7:0]);
        out_bubble_y   <= 8'(CENTER) + ((pitch_r < 0) ? -quoy[7:0] : quoy[7:0]);
      end else begin
        out_roll_out   <= '0;
        out_pitch_out  <= '0;
        out_tilt_class <= CLASS_LEVEL;
        out_bubble_x   <= '0;
        out_bubble_y   <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
